/* design/masked_trimmed_mean_heading_core_defines.svh */
// Assertion macros for the heading core
`ifndef MASKED_TRIMMED_MEAN_HEADING_CORE_DEFINES_SVH
`define MASKED_TRIMMED_MEAN_HEADING_CORE_DEFINES_SVH

`define MTMH_CLK_RST @(posedge clk) disable iff (rst)

`define MTMH_ASSERT(label, prop, msg) \
  label: assert property (`MTMH_CLK_RST prop) else $error(msg);

`endif

/* design/mtmh_pkg.sv */
package mtmh_pkg;

  localparam int CODE_W    = 8;
  localparam int HDG_W     = 9;
  localparam int EST_W     = 10;
  localparam int CNT_W     = 11;
  localparam int SUM_W     = 19;
  localparam int QUO_W     = 9;
  localparam int DIV_W     = SUM_W - QUO_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned MAX_CELLS = 1024;

  localparam logic [CODE_W-1:0] BLOCKED_CODE = 8'd5;
  localparam logic [HDG_W-1:0]  MIN_RESET    = 9'd360;
  localparam logic [CNT_W-1:0]  TRIM_COUNT   = 11'd2;
  localparam logic [CNT_W-1:0]  CNT_LIMIT    = CNT_W'(MAX_CELLS);
  localparam logic [EST_W-1:0]  EST_MAX      = 10'd1022;

  typedef struct packed {
    logic acc;
    logic prep;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic small_count;
  } sts_t;

endpackage

/* design/mtmh_ctrl.sv */
module mtmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_cell,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  mtmh_pkg::sts_t    sts,
  output mtmh_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {RUN, PREP, DIV, LOAD} state_t;

  state_t                      state;
  logic [mtmh_pkg::STEP_W-1:0] step_cnt;

  always_comb begin
    in_ready = (state == RUN);
    cmd.acc  = (state == RUN) && in_valid;
    cmd.prep = (state == PREP);
    cmd.step = (state == DIV);
    cmd.load = (state == LOAD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RUN;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        RUN: begin
          if (in_valid && last_cell) begin
            state <= PREP;
          end
        end
        PREP: begin
          step_cnt <= mtmh_pkg::STEP_W'(mtmh_pkg::DIV_STEPS - 1);
          state    <= sts.small_count ? LOAD : DIV;
        end
        DIV: begin
          if (step_cnt == '0) begin
            state <= LOAD;
          end else begin
            step_cnt <= step_cnt - 1'b1;
          end
        end
        LOAD: begin
          if (cmd.load) begin
            state <= RUN;
          end
        end
        default: begin
          state <= RUN;
        end
      endcase
    end
  end

endmodule

/* design/mtmh_dp.sv */
module mtmh_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mtmh_pkg::CODE_W-1:0]   cell_code,
  input  logic [mtmh_pkg::HDG_W-1:0]    heading,
  input  logic                          last_cell,
  input  mtmh_pkg::cmd_t                cmd,
  output mtmh_pkg::sts_t                sts,
  output logic [mtmh_pkg::EST_W-1:0]    heading_estimate,
  output logic [mtmh_pkg::CNT_W-1:0]    used_cells
);

  logic [mtmh_pkg::SUM_W-1:0] sum, sum_next, fin_sum, dividend;
  logic [mtmh_pkg::CNT_W-1:0] count, count_next, fin_count, divisor_full;
  logic [mtmh_pkg::HDG_W-1:0] min_h, min_next, fin_min;
  logic [mtmh_pkg::HDG_W-1:0] max_h, max_next, fin_max;
  logic [mtmh_pkg::DIV_W-1:0] rem, rem_next, divisor;
  logic [mtmh_pkg::QUO_W-1:0] quot;
  logic [mtmh_pkg::DIV_W:0]   trial, trial_diff;
  logic                       take, ge;

  always_comb begin
    take       = (cell_code != mtmh_pkg::BLOCKED_CODE) && (count < mtmh_pkg::CNT_LIMIT);
    sum_next   = sum;
    count_next = count;
    min_next   = min_h;
    max_next   = max_h;
    if (take) begin
      sum_next   = sum + mtmh_pkg::SUM_W'(heading);
      count_next = count + 1'b1;
      if (count == '0) begin
        min_next = heading;
        max_next = heading;
      end else begin
        if (heading < min_h) min_next = heading;
        if (heading > max_h) max_next = heading;
      end
    end
  end

  // trimmed sum and divisor for the final division, one restoring divider step, and the small-count flag
  always_comb begin
    dividend     = fin_sum - mtmh_pkg::SUM_W'(fin_min) - mtmh_pkg::SUM_W'(fin_max);
    divisor_full = fin_count - mtmh_pkg::TRIM_COUNT;
    trial        = {rem, quot[mtmh_pkg::QUO_W-1]};
    trial_diff   = trial - {1'b0, divisor};
    ge           = (trial >= {1'b0, divisor});
    rem_next     = ge ? trial_diff[mtmh_pkg::DIV_W-1:0] : trial[mtmh_pkg::DIV_W-1:0];
    sts.small_count = (fin_count <= mtmh_pkg::TRIM_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      min_h <= mtmh_pkg::MIN_RESET;
      max_h <= '0;
    end else if (cmd.acc) begin
      if (last_cell) begin
        sum   <= '0;
        count <= '0;
        min_h <= mtmh_pkg::MIN_RESET;
        max_h <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
        min_h <= min_next;
        max_h <= max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last_cell) begin
      fin_sum   <= sum_next;
      fin_count <= count_next;
      fin_min   <= min_next;
      fin_max   <= max_next;
    end
    if (cmd.prep) begin
      rem     <= dividend[mtmh_pkg::SUM_W-1:mtmh_pkg::QUO_W];
      quot    <= dividend[mtmh_pkg::QUO_W-1:0];
      divisor <= divisor_full[mtmh_pkg::DIV_W-1:0];
    end else if (cmd.step) begin
      rem  <= rem_next;
      quot <= {quot[mtmh_pkg::QUO_W-2:0], ge};
    end
    if (cmd.load) begin
      heading_estimate <= sts.small_count ? fin_sum[mtmh_pkg::EST_W-1:0]
                                          : mtmh_pkg::EST_W'(quot);
      used_cells       <= fin_count;
    end
  end

endmodule

/* design/masked_trimmed_mean_heading_core.sv */
// Trimmed-mean heading estimator.
// Input channel (in_valid/in_ready): one grid cell per item with cell_code,
// heading and last_cell. Cells with code 5 are skipped; the rest update a
// running sum, count, min and max (up to 1024 cells per grid).
// Output channel (out_valid/out_ready): one item per grid, sent after the
// item flagged last_cell, carrying heading_estimate and used_cells.
// Throughput: one cell per cycle while a grid streams in. After the last
// cell the input stalls while the result is formed: a prep step, the steps
// of a one-bit-per-cycle restoring divider, then a load step; the divider
// is skipped when two or fewer cells counted.
// The result sits in an output register; the next grid streams in while it
// waits. If the receiver still holds the previous result when a new one is
// ready, the block waits in its load state with in_ready low.
// Reset (rst, synchronous) clears the accumulators and drops out_valid.
`include "masked_trimmed_mean_heading_core_defines.svh"

module masked_trimmed_mean_heading_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mtmh_pkg::CODE_W-1:0]   cell_code,
  input  logic [mtmh_pkg::HDG_W-1:0]    heading,
  input  logic                          last_cell,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtmh_pkg::EST_W-1:0]    heading_estimate,
  output logic [mtmh_pkg::CNT_W-1:0]    used_cells
);

  mtmh_pkg::cmd_t cmd;
  mtmh_pkg::sts_t sts;

  mtmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_cell (last_cell),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtmh_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cell_code        (cell_code),
    .heading          (heading),
    .last_cell        (last_cell),
    .cmd              (cmd),
    .sts              (sts),
    .heading_estimate (heading_estimate),
    .used_cells       (used_cells)
  );

  `MTMH_ASSERT(a_last_stalls_input, (in_valid && in_ready && last_cell) |=> !in_ready, "no stall")
  `MTMH_ASSERT(a_count_in_range, out_valid |-> (used_cells <= mtmh_pkg::CNT_LIMIT), "bad count")
  `MTMH_ASSERT(a_est_in_range, out_valid |-> (heading_estimate <= mtmh_pkg::EST_MAX), "bad est")

endmodule

/* tb/tb_top.sv */
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int N_DIRECTED = 21;

  typedef struct packed {
    logic [mtmh_pkg::EST_W-1:0] est;
    logic [mtmh_pkg::CNT_W-1:0] cnt;
  } heading_result_t;

  typedef struct packed {
    logic [mtmh_pkg::CODE_W-1:0] code;
    logic [mtmh_pkg::HDG_W-1:0]  hdg;
    logic                        last;
    logic                        typed;
    logic [mtmh_pkg::EST_W-1:0]  est;
    logic [mtmh_pkg::CNT_W-1:0]  cnt;
  } directed_cell_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [mtmh_pkg::CODE_W-1:0] cell_code = '0;
  logic [mtmh_pkg::HDG_W-1:0]  heading = '0;
  logic                        last_cell = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [mtmh_pkg::EST_W-1:0]  heading_estimate;
  logic [mtmh_pkg::CNT_W-1:0]  used_cells;

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  bit  hold_request = 1'b0;
  logic hold_off = 1'b0;
  int  mismatches = 0;
  int  cycle_count = 0;
  int  cells_sent = 0;
  int  grids_sent = 0;

  // expected grid results, oldest first
  heading_result_t pending_results[$];

  // accumulator mirror
  logic [mtmh_pkg::SUM_W-1:0] acc_sum;
  logic [mtmh_pkg::CNT_W-1:0] acc_count;
  logic [mtmh_pkg::HDG_W-1:0] acc_min;
  logic [mtmh_pkg::HDG_W-1:0] acc_max;

  // expected values typed in only where obvious; zero typed flag -> mirror decides
  directed_cell_t directed_cells [N_DIRECTED] = '{
    '{mtmh_pkg::BLOCKED_CODE, 9'd0,   1'b1, 1'b1, 10'd0,    11'd0},
    '{8'd0,                   9'd359, 1'b1, 1'b1, 10'd359,  11'd1},
    '{8'd255,                 9'd511, 1'b0, 1'b0, 10'd0,    11'd0},
    '{mtmh_pkg::BLOCKED_CODE, 9'd7,   1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd4,                   9'd511, 1'b1, 1'b1, 10'd1022, 11'd2},
    '{8'd6,                   9'd0,   1'b0, 1'b0, 10'd0,    11'd0},
    '{mtmh_pkg::BLOCKED_CODE, 9'd300, 1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd1,                   9'd511, 1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd2,                   9'd100, 1'b1, 1'b1, 10'd100,  11'd3},
    '{8'd128,                 9'd10,  1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd7,                   9'd20,  1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd127,                 9'd33,  1'b0, 1'b0, 10'd0,    11'd0},
    '{mtmh_pkg::BLOCKED_CODE, 9'd200, 1'b1, 1'b1, 10'd20,   11'd3},
    '{8'd3,                   9'd360, 1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd9,                   9'd400, 1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd170,                 9'd450, 1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd85,                  9'd359, 1'b1, 1'b0, 10'd0,    11'd0},
    '{8'd0,                   9'd0,   1'b1, 1'b1, 10'd0,    11'd1},
    '{8'd3,                   9'd0,   1'b0, 1'b0, 10'd0,    11'd0},
    '{8'd3,                   9'd1,   1'b1, 1'b1, 10'd1,    11'd2},
    '{8'd254,                 9'd256, 1'b1, 1'b1, 10'd256,  11'd1}
  };

  masked_trimmed_mean_heading_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cell_code        (cell_code),
    .heading          (heading),
    .last_cell        (last_cell),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .heading_estimate (heading_estimate),
    .used_cells       (used_cells)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic clear_accumulators();
    acc_sum = '0;
    acc_count = '0;
    acc_min = mtmh_pkg::MIN_RESET;
    acc_max = '0;
  endtask

  task automatic absorb_cell(input logic [mtmh_pkg::CODE_W-1:0] code,
                             input logic [mtmh_pkg::HDG_W-1:0] hdg,
                             input logic last, output bit done,
                             output heading_result_t res);
    logic [mtmh_pkg::SUM_W-1:0] trimmed;
    done = last;
    res = '0;
    if (code != mtmh_pkg::BLOCKED_CODE && acc_count < mtmh_pkg::CNT_LIMIT) begin
      if (acc_count == '0) begin
        acc_min = hdg;
        acc_max = hdg;
      end else begin
        if (hdg < acc_min) acc_min = hdg;
        if (hdg > acc_max) acc_max = hdg;
      end
      acc_sum = acc_sum + mtmh_pkg::SUM_W'(hdg);
      acc_count = acc_count + 1'b1;
    end
    if (last) begin
      if (acc_count > mtmh_pkg::TRIM_COUNT) begin
        trimmed = acc_sum - mtmh_pkg::SUM_W'(acc_min) - mtmh_pkg::SUM_W'(acc_max);
        res.est = mtmh_pkg::EST_W'(trimmed /
                  mtmh_pkg::SUM_W'(acc_count - mtmh_pkg::TRIM_COUNT));
      end else begin
        res.est = mtmh_pkg::EST_W'(acc_sum);
      end
      res.cnt = acc_count;
      clear_accumulators();
    end
  endtask

  task automatic offer_cell(input logic [mtmh_pkg::CODE_W-1:0] code,
                            input logic [mtmh_pkg::HDG_W-1:0] hdg,
                            input logic last, input logic typed,
                            input heading_result_t typed_res);
    bit done;
    heading_result_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_code <= code;
    heading <= hdg;
    last_cell <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_cell(code, hdg, last, done, res);
    if (done) pending_results.push_back(typed ? typed_res : res);
    cells_sent++;
  endtask

  task automatic offer_grid(input int n_cells, input int blocked_pct);
    logic [mtmh_pkg::CODE_W-1:0] code;
    logic [mtmh_pkg::HDG_W-1:0]  hdg;
    for (int i = 0; i < n_cells; i++) begin
      code = ($urandom_range(99) < blocked_pct) ? mtmh_pkg::BLOCKED_CODE
                                                : mtmh_pkg::CODE_W'($urandom);
      case ($urandom_range(9))
        0: hdg = mtmh_pkg::HDG_W'($urandom);
        1: hdg = $urandom_range(1) ? '1 : '0;
        default: hdg = mtmh_pkg::HDG_W'($urandom_range(359));
      endcase
      offer_cell(code, hdg, i == n_cells - 1, 1'b0, '0);
    end
    grids_sent++;
  endtask

  task automatic random_grid();
    int n_cells;
    int blocked_pct;
    case ($urandom_range(9))
      0: n_cells = 1;
      1: n_cells = 2;
      2: n_cells = 3;
      3: n_cells = $urandom_range(40, 10);
      default: n_cells = $urandom_range(8, 1);
    endcase
    case ($urandom_range(7))
      0: blocked_pct = 0;
      1: blocked_pct = 100;
      2: blocked_pct = 50;
      default: blocked_pct = 15;
    endcase
    offer_grid(n_cells, blocked_pct);
  endtask

  task automatic check_result(input logic [mtmh_pkg::EST_W-1:0] est,
                              input logic [mtmh_pkg::CNT_W-1:0] cnt);
    heading_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected item est=%0d cells=%0d", est, cnt));
      return;
    end
    want = pending_results.pop_front();
    if (est !== want.est)
      report_mismatch($sformatf("heading_estimate %0d, want %0d", est, want.est));
    if (cnt !== want.cnt)
      report_mismatch($sformatf("used_cells %0d, want %0d", cnt, want.cnt));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(heading_estimate, used_cells);
      out_ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // long receiver stall so the result register and the load state both fill
  initial begin
    wait (hold_request);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int target_cells;
    int target_grids;
    clear_accumulators();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    in_idle_pct = 13;
    out_stall_pct = 57;
    for (int i = 0; i < N_DIRECTED; i++)
      offer_cell(directed_cells[i].code, directed_cells[i].hdg, directed_cells[i].last,
                 directed_cells[i].typed, '{directed_cells[i].est, directed_cells[i].cnt});
    while (cells_sent < 80 || grids_sent < 10) random_grid();

    in_idle_pct = 57;
    out_stall_pct = 13;
    target_cells = cells_sent + 60;
    target_grids = grids_sent + 10;
    while (cells_sent < target_cells || grids_sent < target_grids) random_grid();

    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_request = 1'b1;
    repeat (8) random_grid();
    // overfull grid: cells past the cap must be ignored
    offer_grid(1040, 0);
    repeat (4) random_grid();
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
